### sv/rtl_pkg.sv
// ============================================================================
// rtl_pkg
// Shared types and constants for the radiance/temperature lookup block.
// ============================================================================
package rtl_pkg;

    localparam int TableDepthDefault = 256;
    localparam int FracBitsDefault   = 16;
    localparam int IdxFrac           = 20;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_FORWARD = 2'd1;
    localparam logic [1:0] FUNC_INVERSE = 2'd2;

    localparam logic [2:0] REG_TEMP_LOW  = 3'd0;
    localparam logic [2:0] REG_TEMP_HIGH = 3'd1;
    localparam logic [2:0] REG_TEMP_STEP = 3'd2;
    localparam logic [2:0] REG_STEP_RECIP = 3'd3;
    localparam logic [2:0] REG_ENTRIES   = 3'd4;

    // Command passed from the front end to the back end through the queue
    typedef struct packed {
        logic        inverse;
        logic [15:0] temperature;
        logic [31:0] radiance;
    } rtl_cmd_t;

endpackage

### sv/rtl_ram.sv
// ============================================================================
// rtl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module rtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/rtl_front.sv
// ============================================================================
// rtl_front
// Input front end: decodes items, performs table loads, and queues lookups.
// ============================================================================
module rtl_front #(
    parameter int TABLE_DEPTH = rtl_pkg::TableDepthDefault
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_func,
    input  logic [7:0]                     s_entry_index,
    input  logic [31:0]                    s_table_word,
    input  logic [15:0]                    s_temperature_in,
    input  logic [31:0]                    s_radiance_in,
    output logic                           load_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] load_addr,
    output logic [31:0]                    load_data,
    output logic                           q_valid,
    input  logic                           q_ready,
    output rtl_pkg::rtl_cmd_t              q_cmd
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Two-entry queue toward the back end
    rtl_pkg::rtl_cmd_t slot_reg [2];
    logic [1:0]        cnt_reg;
    logic              wp_reg, rp_reg;
    logic              push, pop, in_acc, is_lookup;

    // Hold a load until no lookup is queued or busy in the engine
    assign s_ready   = (s_func == rtl_pkg::FUNC_LOAD) ? ((cnt_reg == 2'd0) && q_ready)
                                                      : (cnt_reg != 2'd2);
    assign in_acc    = s_valid && s_ready;
    assign is_lookup = (s_func == rtl_pkg::FUNC_FORWARD) || (s_func == rtl_pkg::FUNC_INVERSE);
    assign push      = in_acc && is_lookup;
    assign q_valid   = (cnt_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_cmd     = slot_reg[rp_reg];

    // Load path: drop slots beyond the table
    assign load_en   = in_acc && (s_func == rtl_pkg::FUNC_LOAD)
                       && ({24'd0, s_entry_index} < TABLE_DEPTH);
    assign load_addr = AW'(s_entry_index);
    assign load_data = s_table_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (push) begin
                slot_reg[wp_reg] <= '{inverse: (s_func == rtl_pkg::FUNC_INVERSE),
                                      temperature: s_temperature_in,
                                      radiance: s_radiance_in};
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### sv/rtl_back.sv
// ============================================================================
// rtl_back
// Lookup engine: forward interpolation and inverse binary search with a
// bit-serial divider. One lookup at a time, table read over the RAM port.
// ============================================================================
module rtl_back #(
    parameter int TABLE_DEPTH = rtl_pkg::TableDepthDefault,
    parameter int FRAC_BITS   = rtl_pkg::FracBitsDefault
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [15:0]                    temp_low,
    input  logic [15:0]                    temp_high,
    input  logic [15:0]                    temp_step,
    input  logic [23:0]                    step_reciprocal,
    input  logic [8:0]                     entries_used,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  rtl_pkg::rtl_cmd_t              q_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  logic [31:0]                    rd_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_result_kind,
    output logic [31:0]                    m_radiance_out,
    output logic [15:0]                    m_temperature_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int FW = FRAC_BITS;
    localparam int DW = 32 + FW;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_R0, S_RLAST, S_FMUL, S_FA, S_FB, S_FMIX,
        S_SRCH, S_SWAIT, S_IR0, S_IR1, S_DIV, S_ISCALE, S_OUT
    } state_t;

    state_t            state_reg;
    rtl_pkg::rtl_cmd_t cmd_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     lo_reg, hi_reg;
    logic [AW-1:0]     addr_reg;
    logic [31:0]       r0_reg, a_reg;
    logic [43:0]       prod_reg;
    logic [FW:0]       f_reg;
    logic [DW-1:0]     rem_reg, den_reg;
    logic [FW:0]       quo_reg;
    logic [5:0]        bit_reg;
    logic [63:0]       acc_reg;
    logic [1:0]        phase_reg;
    logic              kind_reg;
    logic [31:0]       rad_reg;
    logic [15:0]       tmp_reg;

    logic [CW-1:0]     n_eff;
    logic [CW-1:0]     mid;
    logic [43:0]       idx_int;
    logic [FW:0]       f_frac;
    logic [DW:0]       rem_sh;

    assign n_eff = (32'(entries_used) > 32'(TABLE_DEPTH)) ? DEPTH_C : CW'(entries_used);
    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_int = prod_reg >> rtl_pkg::IdxFrac;
    // Fraction of the Q20 index rescaled to FRAC_BITS
    always_comb begin
        if (rtl_pkg::IdxFrac >= FW) begin
            f_frac = (FW+1)'(prod_reg[rtl_pkg::IdxFrac-1:0] >> (rtl_pkg::IdxFrac - FW));
        end else begin
            f_frac = (FW+1)'({20'd0, prod_reg[rtl_pkg::IdxFrac-1:0]}
                             << (FW - rtl_pkg::IdxFrac));
        end
    end
    assign rem_sh  = {rem_reg, 1'b0};
    assign q_ready = (state_reg == S_IDLE);
    assign rd_addr = addr_reg;
    assign m_valid = (state_reg == S_OUT);
    assign m_result_kind     = kind_reg;
    assign m_radiance_out    = rad_reg;
    assign m_temperature_out = tmp_reg;

    // Lookup sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg   <= q_cmd;
                        n_reg     <= n_eff;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    kind_reg <= cmd_reg.inverse;
                    rad_reg  <= 32'd0;
                    // Empty table: inverse answers temp_low, forward answers zero
                    tmp_reg  <= (n_reg == '0 && cmd_reg.inverse) ? temp_low : 16'd0;
                    addr_reg <= '0;
                    phase_reg <= 2'd0;
                    if (n_reg == '0) begin
                        state_reg <= S_OUT;
                    end else if (cmd_reg.inverse) begin
                        state_reg <= S_IR0;
                    end else if (cmd_reg.temperature <= temp_low) begin
                        state_reg <= S_R0;
                    end else if (cmd_reg.temperature >= temp_high) begin
                        addr_reg  <= AW'(n_reg - 1'b1);
                        state_reg <= S_RLAST;
                    end else begin
                        prod_reg  <= 44'(cmd_reg.temperature - temp_low) * 44'(step_reciprocal);
                        state_reg <= S_FMUL;
                    end
                end
                // Single-entry reads, waiting for the registered read data
                S_R0, S_RLAST: begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd1) begin
                        rad_reg   <= rd_data;
                        state_reg <= S_OUT;
                    end
                end
                S_FMUL: begin
                    phase_reg <= 2'd0;
                    f_reg     <= f_frac;
                    if (idx_int >= 44'(n_reg)) begin
                        addr_reg  <= AW'(n_reg - 1'b1);
                        state_reg <= S_RLAST;
                    end else if (idx_int + 44'd1 >= 44'(n_reg)) begin
                        addr_reg  <= AW'(idx_int);
                        state_reg <= S_RLAST;
                    end else begin
                        addr_reg  <= AW'(idx_int);
                        state_reg <= S_FA;
                    end
                end
                S_FA: begin
                    if (phase_reg == 2'd1) begin
                        a_reg     <= rd_data;
                        addr_reg  <= addr_reg + 1'b1;
                        phase_reg <= 2'd0;
                        state_reg <= S_FB;
                    end else begin
                        phase_reg <= phase_reg + 2'd1;
                    end
                end
                S_FB: begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd1) begin
                        acc_reg   <= 64'(a_reg) * 64'((FW+1)'(1) << FW) - 64'(a_reg) * 64'(f_reg);
                        r0_reg    <= rd_data;
                        state_reg <= S_FMIX;
                    end
                end
                S_FMIX: begin
                    rad_reg   <= 32'((acc_reg + 64'(r0_reg) * 64'(f_reg)) >> FW);
                    state_reg <= S_OUT;
                end
                // Inverse: entry 0 check, then last entry, then search
                S_IR0: begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd0) begin
                        addr_reg <= AW'(n_reg - 1'b1);
                    end else if (phase_reg == 2'd1) begin
                        if (cmd_reg.radiance <= rd_data) begin
                            tmp_reg   <= temp_low;
                            state_reg <= S_OUT;
                        end
                    end else begin
                        if (cmd_reg.radiance >= rd_data) begin
                            tmp_reg   <= temp_high;
                            state_reg <= S_OUT;
                        end else begin
                            lo_reg    <= '0;
                            hi_reg    <= n_reg;
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    if (lo_reg < hi_reg) begin
                        addr_reg  <= AW'(mid);
                        phase_reg <= 2'd0;
                        state_reg <= S_SWAIT;
                    end else begin
                        addr_reg  <= AW'(lo_reg - 1'b1);
                        phase_reg <= 2'd0;
                        state_reg <= S_IR1;
                    end
                end
                S_SWAIT: begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd1) begin
                        if (rd_data < cmd_reg.radiance) begin
                            lo_reg <= mid + 1'b1;
                        end else begin
                            hi_reg <= mid;
                        end
                        state_reg <= S_SRCH;
                    end
                end
                // Fetch neighbors lo-1 and lo
                S_IR1: begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd0) begin
                        addr_reg <= AW'(lo_reg);
                    end else if (phase_reg == 2'd1) begin
                        r0_reg <= rd_data;
                    end else begin
                        rem_reg   <= DW'(cmd_reg.radiance - r0_reg);
                        den_reg   <= DW'(rd_data - r0_reg);
                        quo_reg   <= '0;
                        // Skip the division when the fraction is zero
                        bit_reg   <= (rd_data > r0_reg && cmd_reg.radiance > r0_reg) ?
                                     6'(FW + 1) : '0;
                        state_reg <= S_DIV;
                    end
                end
                // Restoring division: one integer step then FW fraction steps
                S_DIV: begin
                    if (bit_reg == '0) begin
                        acc_reg <= (64'(lo_reg - 1'b1) << FW) + 64'(quo_reg);
                        state_reg <= S_ISCALE;
                        phase_reg <= 2'd0;
                    end else begin
                        bit_reg <= bit_reg - 1'b1;
                        if (bit_reg == 6'(FW + 1)) begin
                            // Integer bit is set only when R equals r1
                            if (rem_reg >= den_reg) begin
                                rem_reg <= rem_reg - den_reg;
                                quo_reg <= {quo_reg[FW-1:0], 1'b1};
                            end else begin
                                quo_reg <= {quo_reg[FW-1:0], 1'b0};
                            end
                        end else if (rem_sh >= (DW+1)'(den_reg)) begin
                            rem_reg <= DW'(rem_sh - (DW+1)'(den_reg));
                            quo_reg <= {quo_reg[FW-1:0], 1'b1};
                        end else begin
                            rem_reg <= DW'(rem_sh);
                            quo_reg <= {quo_reg[FW-1:0], 1'b0};
                        end
                    end
                end
                S_ISCALE: begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd0) begin
                        acc_reg <= (acc_reg * 64'(temp_step)) >> FW;
                    end else begin
                        if (acc_reg + 64'(temp_low) > 64'd65535) begin
                            tmp_reg <= 16'hFFFF;
                        end else begin
                            tmp_reg <= 16'(acc_reg + 64'(temp_low));
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### sv/radiance_temperature_lut.sv
// Sequence: forward reads one table entry at the ends, else two and interpolates;
// inverse checks the end entries, else runs a binary search and a bit-serial divider.
// Throughput: one lookup at a time, the next starts once the result is taken;
// a load waits until no lookup is queued or busy, then writes the table.
// Reset: synchronous active-low; registers to defaults, table is not cleared.
// ============================================================================
// radiance_temperature_lut
// Radiance table with forward interpolation and inverse search.
// ============================================================================
module radiance_temperature_lut #(
    parameter int TABLE_DEPTH = rtl_pkg::TableDepthDefault,
    parameter int FRAC_BITS   = rtl_pkg::FracBitsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_entry_index,
    input  logic [31:0] s_table_word,
    input  logic [15:0] s_temperature_in,
    input  logic [31:0] s_radiance_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [31:0] m_radiance_out,
    output logic [15:0] m_temperature_out
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [15:0] temp_low_reg, temp_high_reg, temp_step_reg;
    logic [23:0] step_recip_reg;
    logic [8:0]  entries_reg;

    logic              load_en;
    logic [AW-1:0]     load_addr, rd_addr;
    logic [31:0]       load_data, rd_data;
    logic              q_valid, q_ready;
    rtl_pkg::rtl_cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_low_reg   <= 16'd0;
            temp_high_reg  <= 16'hFFFF;
            temp_step_reg  <= 16'd16;
            step_recip_reg <= 24'd65536;
            entries_reg    <= 9'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rtl_pkg::REG_TEMP_LOW:   temp_low_reg   <= cfg_data[15:0];
                rtl_pkg::REG_TEMP_HIGH:  temp_high_reg  <= cfg_data[15:0];
                rtl_pkg::REG_TEMP_STEP:  temp_step_reg  <= cfg_data[15:0];
                rtl_pkg::REG_STEP_RECIP: step_recip_reg <= cfg_data;
                rtl_pkg::REG_ENTRIES:    entries_reg    <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    rtl_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_func, .s_entry_index,
        .s_table_word, .s_temperature_in, .s_radiance_in,
        .load_en, .load_addr, .load_data, .q_valid, .q_ready, .q_cmd
    );

    rtl_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk, .wr_en(load_en), .wr_addr(load_addr), .wr_data(load_data),
        .rd_addr, .rd_data
    );

    rtl_back #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn,
        .temp_low(temp_low_reg), .temp_high(temp_high_reg),
        .temp_step(temp_step_reg), .step_reciprocal(step_recip_reg),
        .entries_used(entries_reg),
        .q_valid, .q_ready, .q_cmd, .rd_addr, .rd_data,
        .m_valid, .m_ready, .m_result_kind, .m_radiance_out, .m_temperature_out
    );

`ifndef SYNTH
    // A result held under stall keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_radiance_out)
        && $stable(m_temperature_out))
        else $error("result changed while stalled");
    // Forward results carry no temperature
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_kind |-> m_temperature_out == 16'd0)
        else $error("forward result with temperature");
    // A lookup is held off only while the queue is occupied
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && (s_func != rtl_pkg::FUNC_LOAD) |-> q_valid)
        else $error("lookup stalled with empty queue");
`endif

endmodule
